// ----- design/c2smap_pkg.sv -----
// Shared types and constants for the chunk-to-sample map block.
// Used by chunk_to_sample_map_top; the RAM module is generic and needs nothing here.
package c2smap_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 64;

  // Register word indexes on the configuration port.
  localparam logic REG_ENTRY_COUNT = 1'b0;

  // Values of the item kind carried in s_tuser.
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // One run entry as stored in the table memory.
  typedef struct packed {
    logic [31:0] samples_per_chunk;
    logic [31:0] first_chunk;
  } run_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD_FIRST,
    ST_STEP,
    ST_LAST,
    ST_MUL,
    ST_ACC,
    ST_DONE
  } state_t;

endpackage

// ----- design/c2smap_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; contents are undefined until written.
module c2smap_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/chunk_to_sample_map_top.sv -----
// Top level of the chunk-to-sample map: run table, query sequencer, config port.
// Depends on c2smap_pkg and the table memory c2smap_ram.
//
//  Channel   Direction  Handshake                 Payload
//  s_*       in         s_tvalid / s_tready       tdata: table write or query; tuser: kind
//  m_*       out        m_tvalid / m_tready       tdata: first_sample, chunk_samples
//  APB       in/out     psel, penable, pready=1   entry_count at word 0
//
// A table write is taken while idle. A query walks the n used entries (one memory read,
// one multiply and one accumulate per entry through a single 32x32 multiplier),
// and ends early when both answers are settled.
// Reset (rst, synchronous) clears the sequencer, the output valid flag and entry_count;
// the table is not cleared. s_tready is low while a query runs, and a finished
// result waits in the output register while a new item is already taken.
module chunk_to_sample_map_top #(
  parameter int unsigned MAX_ENTRIES = c2smap_pkg::MAX_ENTRIES_DEF,
  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
  localparam int unsigned NW = $clog2(MAX_ENTRIES + 1)
) (
  input  logic         clk,
  input  logic         rst,
  // Input words
  input  logic         s_tvalid,
  output logic         s_tready,
  // [5:0] entry_index, [37:6] first_chunk, [69:38] samples_per_chunk,
  // [101:70] chunk_number, [103:102] zero
  input  logic [103:0] s_tdata,
  // [0] kind
  input  logic         s_tuser,
  // Result words
  output logic         m_tvalid,
  input  logic         m_tready,
  // [31:0] first_sample, [63:32] chunk_samples
  output logic [63:0]  m_tdata,
  // Configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  c2smap_pkg::state_t state, state_next;

  logic [6:0]  entry_count;
  logic [5:0]  in_entry_index;
  logic [31:0] in_first_chunk;
  logic [31:0] in_samples;
  logic [31:0] in_chunk;

  logic [NW-1:0] used;
  logic [AW-1:0] idx;
  logic [AW-1:0] rd_addr;
  logic          idx_is_last;
  logic          accept;
  logic          tbl_we;

  c2smap_pkg::run_entry_t wr_entry;
  c2smap_pkg::run_entry_t rd_entry;

  logic [31:0] chunk;
  logic [31:0] cur;
  logic [31:0] cnt;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [31:0] prod;
  logic [31:0] sum;
  logic [31:0] samples;
  logic        sum_done;
  logic        found;

  logic [31:0] nxt;
  logic [31:0] step_b;
  logic        step_stop;
  logic        step_hit;

  assign in_entry_index = s_tdata[5:0];
  assign in_first_chunk = s_tdata[37:6];
  assign in_samples     = s_tdata[69:38];
  assign in_chunk       = s_tdata[101:70];

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == c2smap_pkg::REG_ENTRY_COUNT) ? {25'd0, entry_count} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= 7'd0;
    end else if (psel && penable && pwrite && paddr[2] == c2smap_pkg::REG_ENTRY_COUNT) begin
      entry_count <= pwdata[6:0];
    end
  end

  // A count above the table size acts as the table size.
  always_comb begin
    if ({25'd0, entry_count} > 32'(MAX_ENTRIES)) begin
      used = NW'(MAX_ENTRIES);
    end else begin
      used = NW'(entry_count);
    end
  end

  assign s_tready = (state == c2smap_pkg::ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // Table memory
  assign tbl_we   = accept && (s_tuser == c2smap_pkg::KIND_WRITE) &&
                    (32'(in_entry_index) < 32'(MAX_ENTRIES));
  assign wr_entry = '{samples_per_chunk: in_samples, first_chunk: in_first_chunk};
  // Idle reads entry 0 so it is ready for a query; otherwise the entry after idx.
  assign rd_addr  = (state == c2smap_pkg::ST_IDLE) ? '0 : AW'(idx + 1'b1);

  c2smap_ram #(
    .WIDTH ($bits(c2smap_pkg::run_entry_t)),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (AW'(in_entry_index)),
    .wdata (wr_entry),
    .raddr (rd_addr),
    .rdata (rd_entry)
  );

  assign idx_is_last = (NW'(idx) == NW'(used - 1'b1));

  // One walk step: cur/cnt hold entry idx, the memory delivers entry idx+1.
  assign nxt = rd_entry.first_chunk;
  always_comb begin
    step_b    = 32'd0;
    step_stop = 1'b0;
    if (!sum_done) begin
      if (chunk > cur) begin
        if (chunk < nxt) begin
          step_b    = chunk - cur;
          step_stop = 1'b1;
        end else begin
          step_b = nxt - cur;
        end
      end else if (chunk == cur) begin
        step_stop = 1'b1;
      end
    end
    step_hit = !found && (chunk >= cur) && (chunk < nxt);
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= c2smap_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      c2smap_pkg::ST_IDLE: begin
        if (accept && s_tuser == c2smap_pkg::KIND_QUERY) begin
          state_next = (used == '0) ? c2smap_pkg::ST_DONE : c2smap_pkg::ST_LOAD_FIRST;
        end
      end
      c2smap_pkg::ST_LOAD_FIRST: begin
        state_next = (used == NW'(1)) ? c2smap_pkg::ST_LAST : c2smap_pkg::ST_STEP;
      end
      c2smap_pkg::ST_STEP: state_next = c2smap_pkg::ST_MUL;
      c2smap_pkg::ST_LAST: state_next = c2smap_pkg::ST_MUL;
      c2smap_pkg::ST_MUL:  state_next = c2smap_pkg::ST_ACC;
      c2smap_pkg::ST_ACC: begin
        if (sum_done && found) begin
          state_next = c2smap_pkg::ST_DONE;
        end else if (idx_is_last) begin
          state_next = c2smap_pkg::ST_LAST;
        end else begin
          state_next = c2smap_pkg::ST_STEP;
        end
      end
      c2smap_pkg::ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = c2smap_pkg::ST_IDLE;
        end
      end
      default: state_next = c2smap_pkg::ST_IDLE;
    endcase
  end

  // Walk datapath
  always_ff @(posedge clk) begin
    case (state)
      c2smap_pkg::ST_IDLE: begin
        // idx starts at zero so the first-entry cycle fetches entry 1.
        idx      <= '0;
        chunk    <= in_chunk;
        sum      <= 32'd0;
        samples  <= 32'd0;
        sum_done <= 1'b0;
        found    <= 1'b0;
      end
      c2smap_pkg::ST_LOAD_FIRST: begin
        cur <= rd_entry.first_chunk;
        cnt <= rd_entry.samples_per_chunk;
        idx <= '0;
      end
      c2smap_pkg::ST_STEP: begin
        mul_a <= cnt;
        mul_b <= step_b;
        if (step_stop) begin
          sum_done <= 1'b1;
        end
        if (step_hit) begin
          samples <= cnt;
          found   <= 1'b1;
        end
        cur <= nxt;
        cnt <= rd_entry.samples_per_chunk;
        idx <= AW'(idx + 1'b1);
      end
      c2smap_pkg::ST_LAST: begin
        // The last entry takes the rest of the sum and is the fallback count.
        mul_a <= cnt;
        mul_b <= sum_done ? 32'd0 : chunk - cur;
        if (!found) begin
          samples <= cnt;
        end
        sum_done <= 1'b1;
        found    <= 1'b1;
      end
      c2smap_pkg::ST_MUL: begin
        prod <= mul_a * mul_b;
      end
      c2smap_pkg::ST_ACC: begin
        sum <= sum + prod;
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == c2smap_pkg::ST_DONE && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == c2smap_pkg::ST_DONE && (!m_tvalid || m_tready)) begin
      m_tdata <= {samples, sum + 32'd1};
    end
  end

endmodule

// ----- dv/tb_chunk_to_sample_map_top.sv -----
// Self-checking testbench for chunk_to_sample_map_top: run table writes, chunk queries,
// entry_count settings and stream stalls, each query answer checked against a local predictor.
// Depends on c2smap_pkg and the RTL of the block; it needs no files or arguments.
module tb_chunk_to_sample_map_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TABLE_DEPTH = c2smap_pkg::MAX_ENTRIES_DEF;
  // Long enough for the longest query; this covers a write or query still in flight.
  localparam int unsigned DRAIN_CYCLES = 250;
  // Longest correct quiet stretch: receiver hold-off plus a full query plus a drain.
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned RANDOM_ITEMS = 1400;

  typedef struct {
    logic [31:0] first_sample;
    logic [31:0] chunk_samples;
  } answer_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  // [5:0] entry_index, [37:6] first_chunk, [69:38] samples_per_chunk,
  // [101:70] chunk_number, [103:102] zero
  logic [103:0] s_tdata = '0;
  // [0] kind
  logic         s_tuser = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  // [31:0] first_sample, [63:32] chunk_samples
  logic [63:0]  m_tdata;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  chunk_to_sample_map_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 0;
  end

  // Local copy of the table and the register, updated as words are accepted.
  logic [31:0]  tbl_first_chunk [TABLE_DEPTH];
  logic [31:0]  tbl_run_samples [TABLE_DEPTH];
  logic [6:0]   model_entry_count = '0;
  answer_t      pending_answers [$];
  answer_t      oldest_answer;

  int unsigned  mismatches = 0;
  int unsigned  words_sent = 0;
  int unsigned  burst_left = 0;
  bit           sender_gaps = 1'b1;
  int unsigned  hold_off_cycles = 0;
  int unsigned  quiet_cycles = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < 100)
      $display("ERROR at %0t ns: %s: got %h, want %h", $time, what, got, want);
    mismatches++;
  endtask

  function automatic int unsigned used_entries();
    return (model_entry_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(model_entry_count);
  endfunction

  // Walk the runs before the queried chunk, summing count times run length, wrapping.
  function automatic logic [31:0] first_sample_for(input logic [31:0] chunk,
                                                   input int unsigned n);
    logic [31:0] sum;
    logic [31:0] cur;
    logic [31:0] cnt;
    logic [31:0] nxt;
    sum = '0;
    for (int unsigned i = 0; i < n; i++) begin
      cur = tbl_first_chunk[i];
      cnt = tbl_run_samples[i];
      if (i + 1 == n) begin
        sum += cnt * (chunk - cur);
        break;
      end
      nxt = tbl_first_chunk[i + 1];
      if (chunk > cur) begin
        if (chunk < nxt) begin
          sum += cnt * (chunk - cur);
          break;
        end
        sum += cnt * (nxt - cur);
      end else if (chunk == cur) begin
        break;
      end
    end
    return sum + 32'd1;
  endfunction

  function automatic logic [31:0] chunk_samples_for(input logic [31:0] chunk,
                                                    input int unsigned n);
    if (n == 0)
      return '0;
    for (int unsigned i = 0; i + 1 < n; i++) begin
      if (chunk >= tbl_first_chunk[i] && chunk < tbl_first_chunk[i + 1])
        return tbl_run_samples[i];
    end
    return tbl_run_samples[n - 1];
  endfunction

  function automatic logic [31:0] nonzero_random();
    logic [31:0] v;
    v = $urandom;
    return (v == 0) ? 32'd1 : v;
  endfunction

  // Sends one word in bursts with random gaps, then updates the local table
  // or queues the answer once the word has been accepted.
  task automatic send_word(input logic kind, input logic [5:0] slot,
                           input logic [31:0] first_chunk, input logic [31:0] spc,
                           input logic [31:0] chunk);
    answer_t ans;
    if (sender_gaps && burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {2'b00, chunk, spc, first_chunk, slot};
    do @(posedge clk); while (!s_tready);
    if (burst_left > 0)
      burst_left--;
    words_sent++;
    if (kind == c2smap_pkg::KIND_WRITE) begin
      tbl_first_chunk[slot] = first_chunk;
      tbl_run_samples[slot] = spc;
    end else begin
      ans.first_sample  = first_sample_for(chunk, used_entries());
      ans.chunk_samples = chunk_samples_for(chunk, used_entries());
      pending_answers.insert(pending_answers.size(), ans);
    end
  endtask

  task automatic write_entry(input logic [5:0] slot, input logic [31:0] first_chunk,
                             input logic [31:0] spc);
    send_word(c2smap_pkg::KIND_WRITE, slot, first_chunk, spc, nonzero_random());
  endtask

  task automatic query_chunk(input logic [31:0] chunk);
    send_word(c2smap_pkg::KIND_QUERY, 6'($urandom), nonzero_random(), $urandom, chunk);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes entry_count over the configuration port and reads it back.
  task automatic set_entry_count(input logic [6:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {c2smap_pkg::REG_ENTRY_COUNT, 2'b00};
    pwdata  <= {25'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    model_entry_count = value;
    @(posedge clk);
    psel <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== {25'd0, value})
      report_mismatch("entry_count read back", prdata, {25'd0, value});
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [31:0] random_count();
    return ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 2000);
  endfunction

  // Fills slots 0..n-1, mostly as an ascending run list, sometimes with repeats
  // of a first chunk, or as an arbitrary unsorted list.
  task automatic fill_table(input int unsigned n, input bit sorted);
    logic [31:0] fc;
    logic [31:0] step_max;
    fc = $urandom_range(0, 1) ? 32'd1 : $urandom_range(1, 100);
    step_max = 32'hFFFF_FFF0 / (n + 1);
    for (int unsigned i = 0; i < n; i++) begin
      if (!sorted)
        fc = nonzero_random();
      write_entry(6'(i), fc, random_count());
      case ($urandom_range(0, 9))
        0:       fc = fc;
        1, 2, 3, 4, 5, 6: fc = fc + $urandom_range(1, 16);
        default: fc = fc + $urandom_range(1, step_max);
      endcase
    end
  endtask

  // Chunk numbers cluster around run boundaries, with some from the full range.
  function automatic logic [31:0] pick_chunk(input int unsigned n);
    logic [31:0] base;
    logic [31:0] c;
    if (n == 0)
      return nonzero_random();
    base = tbl_first_chunk[$urandom_range(0, n - 1)];
    case ($urandom_range(0, 7))
      0:       c = base;
      1:       c = base - 1;
      2:       c = base + 1;
      3:       c = base + $urandom_range(0, 50);
      4:       c = 32'd1;
      5:       c = 32'hFFFF_FFFF;
      default: c = $urandom;
    endcase
    return (c == 0) ? 32'd1 : c;
  endfunction

  task automatic test_empty_table();
    query_chunk(32'd1);
    query_chunk(32'hFFFF_FFFF);
    wait_idle();
  endtask

  task automatic test_run_boundaries();
    write_entry(6'd0, 32'd1, 32'hFFFF_FFFF);
    write_entry(6'd1, 32'd5, 32'd0);
    write_entry(6'd2, 32'd9, 32'd3);
    write_entry(6'd3, 32'hFFFF_FFFF, 32'd7);
    write_entry(6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    wait_idle();
    set_entry_count(7'd1);
    query_chunk(32'd1);
    query_chunk(32'hFFFF_FFFF);
    wait_idle();
    set_entry_count(7'd4);
    query_chunk(32'd1);
    query_chunk(32'd4);
    query_chunk(32'd5);
    query_chunk(32'd8);
    query_chunk(32'd9);
    query_chunk(32'd100);
    query_chunk(32'hFFFF_FFFE);
    query_chunk(32'hFFFF_FFFF);
    wait_idle();
  endtask

  task automatic test_unsorted_runs();
    write_entry(6'd1, 32'd3, 32'd11);
    write_entry(6'd2, 32'd2, 32'd13);
    query_chunk(32'd2);
    query_chunk(32'd3);
    query_chunk(32'd5);
    wait_idle();
  endtask

  // All 64 slots, then counts at, just above and far above the table size.
  task automatic test_full_table_and_oversized_count();
    fill_table(TABLE_DEPTH, 1'b1);
    wait_idle();
    for (int k = 0; k < 3; k++) begin
      set_entry_count((k == 0) ? 7'd64 : (k == 1) ? 7'd65 : 7'd127);
      repeat (8) query_chunk(pick_chunk(used_entries()));
      wait_idle();
    end
  endtask

  // The receiver holds off while queries keep coming, so the block fills and stalls.
  task automatic test_output_backpressure();
    set_entry_count(7'd6);
    sender_gaps = 1'b0;
    hold_off_cycles = 400;
    repeat (24) query_chunk(pick_chunk(used_entries()));
    sender_gaps = 1'b1;
    wait_idle();
  endtask

  task automatic test_random_tables();
    int unsigned r;
    logic [6:0]  count;
    int unsigned target;
    target = words_sent + RANDOM_ITEMS;
    while (words_sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 5)       count = 7'd0;
      else if (r < 60) count = 7'($urandom_range(1, 8));
      else if (r < 85) count = 7'($urandom_range(9, 32));
      else if (r < 95) count = 7'($urandom_range(33, 64));
      else             count = 7'($urandom_range(65, 127));
      set_entry_count(count);
      sender_gaps = ($urandom_range(0, 3) != 0);
      fill_table(used_entries(), $urandom_range(0, 3) != 0);
      repeat (30) begin
        if ($urandom_range(0, 99) < 85)
          query_chunk(pick_chunk(used_entries()));
        else
          write_entry(6'($urandom), nonzero_random(), random_count());
      end
      wait_idle();
    end
    sender_gaps = 1'b1;
  endtask

  // Receiver: steps through four stall patterns in turn, or holds off when asked.
  initial begin : result_sink
    int unsigned cyc;
    cyc = 0;
    forever begin
      @(posedge clk);
      if (hold_off_cycles != 0) begin
        m_tready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
      end else begin
        cyc++;
        case ((cyc / 300) % 4)
          0:       m_tready <= 1'b1;
          1:       m_tready <= ($urandom_range(0, 3) != 0);
          2:       m_tready <= ((cyc % 8) < 5);
          default: m_tready <= ($urandom_range(0, 2) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("result word with no query waiting", m_tdata[31:0], '0);
      end else begin
        oldest_answer = pending_answers.pop_front();
        if (m_tdata[31:0] !== oldest_answer.first_sample)
          report_mismatch("first_sample", m_tdata[31:0], oldest_answer.first_sample);
        if (m_tdata[63:32] !== oldest_answer.chunk_samples)
          report_mismatch("chunk_samples", m_tdata[63:32], oldest_answer.chunk_samples);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_table();
    test_run_boundaries();
    test_unsorted_runs();
    test_full_table_and_oversized_count();
    test_output_backpressure();
    test_random_tables();
    wait_idle();
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
